>>> hdl/revolution_ring_generator_unit_defines.svh
// assertion macros used by the checker
`ifndef REVOLUTION_RING_GENERATOR_UNIT_DEFINES_SVH
`define REVOLUTION_RING_GENERATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define RRG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define RRG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/rrg_pkg.sv
package rrg_pkg;

  localparam int CFG_W      = 18;
  localparam int COEFF_W    = 18;
  localparam int STEPS_W    = 6;
  localparam int PX_W       = 9;
  localparam int PY_W       = 10;
  localparam int PZ_W       = 10;
  localparam int V_W        = 20;
  localparam int VY_W       = 10;
  localparam int PROD_W     = COEFF_W + V_W;
  localparam int ACC_W      = PROD_W + 1;

  localparam logic [STEPS_W-1:0] MAX_STEPS = 6'd49;

  localparam logic signed [COEFF_W-1:0] COS_RESET   = 18'sd53020;
  localparam logic signed [COEFF_W-1:0] SIN_RESET   = 18'sd38521;
  localparam logic [STEPS_W-1:0]        STEPS_RESET = 6'd10;

  localparam logic [1:0] CFG_COS   = 2'd0;
  localparam logic [1:0] CFG_SIN   = 2'd1;
  localparam logic [1:0] CFG_STEPS = 2'd2;

  typedef enum logic [2:0] {
    PH_NONE,
    PH_CX,
    PH_SZ,
    PH_CZ,
    PH_SX,
    PH_UPD
  } ph_t;

  typedef struct packed {
    logic load;
    ph_t  ph;
  } cmd_t;

  typedef struct packed {
    logic last;
  } stat_t;

  // round half up, drop 16 fraction bits, clamp to 20 bits
  function automatic logic signed [V_W-1:0] rnd_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W:0] t;
    logic signed [ACC_W-16:0] r;
    t = {v[ACC_W-1], v} + (ACC_W+1)'(32768);
    r = t[ACC_W:16];
    if (r > (ACC_W-15)'(signed'(524287))) begin
      rnd_sat = 20'sd524287;
    end else if (r < -(ACC_W-15)'(signed'(524288))) begin
      rnd_sat = -20'sd524288;
    end else begin
      rnd_sat = r[V_W-1:0];
    end
  endfunction

endpackage

>>> hdl/revolution_ring_generator_unit.sv
// channel   direction  payload
// in_       input      px, py, pz, first_point, last_point
// out_      output     vx, vy, vz, ring_index, last_vertex
// cfg_      input      index 0 cos, 1 sin, 2 ring_steps
//
// an end point gives one vertex
// a middle point gives steps+1 vertices, steps being ring_steps capped at 49;
// a rotation step takes four products on the one shared 18x20 multiplier,
// then an update step and a vertex step
// one item in flight; in_ready is high only while idle; a stall freezes the ring
// reset is synchronous, active low, and loads the register defaults
module revolution_ring_generator_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [rrg_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rrg_pkg::PX_W-1:0]            in_px,
  input  logic [rrg_pkg::PY_W-1:0]            in_py,
  input  logic signed [rrg_pkg::PZ_W-1:0]     in_pz,
  input  logic                                in_first_point,
  input  logic                                in_last_point,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rrg_pkg::V_W-1:0]      out_vx,
  output logic signed [rrg_pkg::VY_W-1:0]     out_vy,
  output logic signed [rrg_pkg::V_W-1:0]      out_vz,
  output logic [rrg_pkg::STEPS_W-1:0]         out_ring_index,
  output logic                                out_last_vertex
);
  import rrg_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rrg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_both   (in_first_point & in_last_point),
    .out_ready (out_ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  rrg_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_px           (in_px),
    .in_py           (in_py),
    .in_pz           (in_pz),
    .in_first_point  (in_first_point),
    .in_last_point   (in_last_point),
    .cmd             (cmd),
    .stat            (stat),
    .out_vx          (out_vx),
    .out_vy          (out_vy),
    .out_vz          (out_vz),
    .out_ring_index  (out_ring_index),
    .out_last_vertex (out_last_vertex)
  );

endmodule

>>> hdl/rrg_ctrl.sv
module rrg_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_both,
  input  logic         out_ready,
  input  rrg_pkg::stat_t stat,
  output logic         in_ready,
  output logic         out_valid,
  output rrg_pkg::cmd_t  cmd
);
  import rrg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHOW,
    S_CX,
    S_SZ,
    S_CZ,
    S_SX,
    S_UPD
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.ph    = PH_NONE;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid && !in_both) state_nxt = S_SHOW;
      end
      S_SHOW: begin
        if (out_ready) state_nxt = stat.last ? S_IDLE : S_CX;
      end
      S_CX: begin
        cmd.ph = PH_CX;
        state_nxt = S_SZ;
      end
      S_SZ: begin
        cmd.ph = PH_SZ;
        state_nxt = S_CZ;
      end
      S_CZ: begin
        cmd.ph = PH_CZ;
        state_nxt = S_SX;
      end
      S_SX: begin
        cmd.ph = PH_SX;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.ph = PH_UPD;
        state_nxt = S_SHOW;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_SHOW);

endmodule

>>> hdl/rrg_datapath.sv
module rrg_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [rrg_pkg::CFG_W-1:0]           cfg_data,
  input  logic [rrg_pkg::PX_W-1:0]            in_px,
  input  logic [rrg_pkg::PY_W-1:0]            in_py,
  input  logic signed [rrg_pkg::PZ_W-1:0]     in_pz,
  input  logic                                in_first_point,
  input  logic                                in_last_point,
  input  rrg_pkg::cmd_t                       cmd,
  output rrg_pkg::stat_t                      stat,
  output logic signed [rrg_pkg::V_W-1:0]      out_vx,
  output logic signed [rrg_pkg::VY_W-1:0]     out_vy,
  output logic signed [rrg_pkg::V_W-1:0]      out_vz,
  output logic [rrg_pkg::STEPS_W-1:0]         out_ring_index,
  output logic                                out_last_vertex
);
  import rrg_pkg::*;

  logic signed [COEFF_W-1:0] cos_r, sin_r;
  logic [STEPS_W-1:0]        ring_steps_r;

  logic signed [V_W-1:0]     x_r, z_r, nx_r;
  logic signed [VY_W-1:0]    y_r;
  logic [STEPS_W-1:0]        steps_r, j_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;

  logic signed [COEFF_W-1:0] ma;
  logic signed [V_W-1:0]     mb;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [PZ_W-1:0]    dx;
  logic signed [PY_W:0]      dy;
  logic                      is_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r        <= COS_RESET;
      sin_r        <= SIN_RESET;
      ring_steps_r <= STEPS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COS:   cos_r        <= cfg_data[COEFF_W-1:0];
        CFG_SIN:   sin_r        <= cfg_data[COEFF_W-1:0];
        CFG_STEPS: ring_steps_r <= cfg_data[STEPS_W-1:0];
        default:   ;
      endcase
    end
  end

  assign is_end   = in_first_point | in_last_point;
  assign dx       = $signed({1'b0, in_px}) - 10'sd200;
  assign dy       = $signed({1'b0, in_py}) - 11'sd300;

  // shared multiplier operand select
  assign ma       = (cmd.ph == PH_CX || cmd.ph == PH_CZ) ? cos_r : sin_r;
  assign mb       = (cmd.ph == PH_CX || cmd.ph == PH_SX) ? x_r : z_r;
  assign prod     = ma * mb;
  assign prod_ext = {prod_r[PROD_W-1], prod_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= is_end ? '0 : {{2{dx[PZ_W-1]}}, dx, 8'b0};
      z_r     <= {{2{in_pz[PZ_W-1]}}, in_pz, 8'b0};
      y_r     <= (dy > 11'sd511) ? 10'sd511 : dy[VY_W-1:0];
      steps_r <= is_end ? '0 : ((ring_steps_r > MAX_STEPS) ? MAX_STEPS : ring_steps_r);
      j_r     <= '0;
    end else begin
      case (cmd.ph)
        PH_CX: prod_r <= prod;
        PH_SZ: begin
          acc_r  <= prod_ext;
          prod_r <= prod;
        end
        PH_CZ: begin
          nx_r   <= rnd_sat(acc_r + prod_ext);
          prod_r <= prod;
        end
        PH_SX: begin
          acc_r  <= prod_ext;
          prod_r <= prod;
        end
        PH_UPD: begin
          x_r <= nx_r;
          z_r <= rnd_sat(acc_r - prod_ext);
          j_r <= j_r + 6'd1;
        end
        default: ;
      endcase
    end
  end

  assign stat.last       = (j_r == steps_r);
  assign out_vx          = x_r;
  assign out_vy          = y_r;
  assign out_vz          = z_r;
  assign out_ring_index  = j_r;
  assign out_last_vertex = stat.last;

endmodule

>>> hdl/rrg_checker.sv
`include "revolution_ring_generator_unit_defines.svh"

module rrg_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                in_first_point,
  input logic                                in_last_point,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [rrg_pkg::V_W-1:0]      out_vx,
  input logic signed [rrg_pkg::V_W-1:0]      out_vz,
  input logic [rrg_pkg::STEPS_W-1:0]         out_ring_index,
  input logic                                out_last_vertex
);

  // a stalled vertex holds
  `RRG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_vx) && $stable(out_vz) && $stable(out_ring_index))

  // an end point gives one axis vertex
  `RRG_ASSERT_NEXT(a_end_vertex, in_valid && in_ready && (in_first_point != in_last_point), out_valid && out_last_vertex && out_ring_index == 6'd0 && out_vx == 20'sd0)

  // a single-point profile gives nothing
  `RRG_ASSERT_NEXT(a_single, in_valid && in_ready && in_first_point && in_last_point, !out_valid && in_ready)

  // no new transfer while a ring is still open
  `RRG_ASSERT_NEXT(a_ring_busy, out_valid && out_ready && !out_last_vertex, !in_ready && !out_valid)

endmodule

bind revolution_ring_generator_unit rrg_checker u_rrg_checker (.*);
